// ===== hdl/dts_pkg.sv =====
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types, result codes and constants of the delimited token splitter.
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam int RES_CAP = 4;
  localparam int IDX_W   = $clog2(RES_CAP);
  localparam int CNT_W   = $clog2(RES_CAP + 1);
  localparam int COUNT_W = 7;

  localparam logic [1:0] KIND_BYTE      = 2'd0;
  localparam logic [1:0] KIND_TOKEN_END = 2'd1;
  localparam logic [1:0] KIND_LINE_END  = 2'd2;
  localparam logic [1:0] KIND_ERROR     = 2'd3;

  localparam logic [7:0] SPACE_BYTE  = 8'h20;
  localparam logic [7:0] ESCAPE_BYTE = 8'h5C;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         data;
    logic [COUNT_W-1:0] count;
  } res_t;

  typedef res_t [RES_CAP-1:0] res_vec_t;

  // Places one result in the next free slot; results past the cap are dropped.
  function automatic void dts_emit(inout res_vec_t r, inout logic [CNT_W-1:0] n,
                                   input logic [1:0] kind, input logic [7:0] data,
                                   input logic [COUNT_W-1:0] count);
    if (n < CNT_W'(RES_CAP)) begin
      r[n[IDX_W-1:0]].kind  = kind;
      r[n[IDX_W-1:0]].data  = data;
      r[n[IDX_W-1:0]].count = count;
      n = n + CNT_W'(1);
    end
  endfunction

endpackage

// ===== hdl/dts_burst.sv =====
// ----------------------------------------------------------------------------
// dts_burst
// Holds the results of one byte and hands them out one beat at a time.
// ----------------------------------------------------------------------------
module dts_burst
  import dts_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  res_vec_t         load_res,
  input  logic [CNT_W-1:0] load_cnt,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_stall,
  output res_t             head,
  output logic             head_last
);

  res_vec_t         slots_r, slots_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  // A new byte may load while the final beat of the previous one leaves.
  assign ready     = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && !out_stall);
  assign head      = slots_r[0];
  assign head_last = (cnt_r == CNT_W'(1));

  always_comb begin
    slots_nxt = slots_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      slots_nxt = load_res;
      cnt_nxt   = load_cnt;
    end else if (pop) begin
      slots_nxt = res_vec_t'(slots_r >> $bits(res_t));
      cnt_nxt   = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slots_r <= slots_nxt;
  end

endmodule

// ===== hdl/delimited_token_splitter.sv =====
// ----------------------------------------------------------------------------
// delimited_token_splitter
// Splits a command line, one byte per beat, into token bytes, token ends,
// a line end with the token count, or a syntax error.
// ----------------------------------------------------------------------------
// Each accepted byte is decoded in the cycle it is accepted and its results
// (zero to four) are loaded into a small burst buffer that feeds the output
// one beat per cycle while out_stall is low. A byte is taken every cycle as
// long as each byte gives at most one result and the output is not stalled;
// a byte that gives more results holds off the input while the single-beat
// output port drains the buffer. The next byte is taken in the same cycle as
// the last beat of the previous one leaves. The delimiter register may be
// written only while the block is idle; a space delimiter splits everywhere,
// any other one only at line start or after a space.
module delimited_token_splitter
  import dts_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = 256,
  parameter int MAX_TOKENS    = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_byte,
  input  logic               in_line_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_byte,
  output logic [COUNT_W-1:0] out_tokens_found,
  output logic               out_run_last
);

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN);
  localparam int TOT_W = $clog2(MAX_TOKENS + 1);

  typedef struct packed {
    logic             esc;
    logic [7:0]       prev;
    logic             ls;
    logic [LEN_W-1:0] tlen;
    logic [TOT_W-1:0] ttot;
    logic             failed;
  } st_t;

  st_t              st_r, st_nxt;
  logic [7:0]       delim_r;
  res_vec_t         res;
  logic [CNT_W-1:0] res_cnt;
  logic             ready;
  logic             in_accept;
  res_t             head;

  function automatic st_t line_clear();
    st_t s;
    s    = '0;
    s.ls = 1'b1;
    return s;
  endfunction

  function automatic void do_fail(inout st_t s, inout res_vec_t r,
                                  inout logic [CNT_W-1:0] n);
    if (!s.failed) begin
      dts_emit(r, n, KIND_ERROR, 8'h00, '0);
      s.failed = 1'b1;
    end
  endfunction

  function automatic void do_append(inout st_t s, inout res_vec_t r,
                                    inout logic [CNT_W-1:0] n, input logic [7:0] c);
    if (s.tlen >= LEN_W'(MAX_TOKEN_LEN - 1)) begin
      do_fail(s, r, n);
    end else begin
      dts_emit(r, n, KIND_BYTE, c, '0);
      s.tlen = s.tlen + LEN_W'(1);
    end
  endfunction

  function automatic void do_end(inout st_t s, inout res_vec_t r,
                                 inout logic [CNT_W-1:0] n);
    if (s.ttot >= TOT_W'(MAX_TOKENS)) begin
      do_fail(s, r, n);
    end else begin
      dts_emit(r, n, KIND_TOKEN_END, 8'h00, '0);
      s.ttot = s.ttot + TOT_W'(1);
      s.tlen = '0;
    end
  endfunction

  function automatic void do_plain(inout st_t s, inout res_vec_t r,
                                   inout logic [CNT_W-1:0] n,
                                   input logic [7:0] c, input logic [7:0] d);
    if (!s.failed) begin
      if ((c == d) && ((d == SPACE_BYTE) || (s.prev == SPACE_BYTE) || s.ls)) begin
        if (s.tlen == '0) begin
          // An empty token is only legal with a space delimiter.
          if (d != SPACE_BYTE) begin
            do_fail(s, r, n);
          end
        end else begin
          do_end(s, r, n);
        end
      end else if (!((s.tlen == '0) && (c == SPACE_BYTE))) begin
        do_append(s, r, n, c);
      end
      s.prev = c;
      s.ls   = 1'b0;
    end
  endfunction

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = !ready;

  always_comb begin
    st_t              s;
    res_vec_t         r;
    logic [CNT_W-1:0] n;
    logic             consumed;
    s        = st_r;
    r        = '0;
    n        = '0;
    consumed = 1'b0;
    if (!s.failed) begin
      if (in_line_last && (in_char_byte == delim_r) && (delim_r != SPACE_BYTE)) begin
        do_fail(s, r, n);
      end else begin
        if (s.esc) begin
          s.esc = 1'b0;
          if (in_char_byte == delim_r) begin
            // Escaped delimiter goes into the token as a plain byte.
            do_append(s, r, n, in_char_byte);
            s.prev   = in_char_byte;
            s.ls     = 1'b0;
            consumed = 1'b1;
          end else begin
            do_plain(s, r, n, ESCAPE_BYTE, delim_r);
          end
        end
        if (!consumed && !s.failed) begin
          if (!in_line_last && (in_char_byte == ESCAPE_BYTE)) begin
            s.esc = 1'b1;
          end else begin
            do_plain(s, r, n, in_char_byte, delim_r);
          end
        end
      end
    end
    if (in_line_last) begin
      if (!s.failed) begin
        if (s.tlen != '0) begin
          do_end(s, r, n);
        end
        if (!s.failed) begin
          dts_emit(r, n, KIND_LINE_END, 8'h00, COUNT_W'(s.ttot));
        end
      end
      s = line_clear();
    end
    st_nxt  = s;
    res     = r;
    res_cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= line_clear();
      delim_r <= SPACE_BYTE;
    end else begin
      if (in_accept) begin
        st_r <= st_nxt;
      end
      if (cfg_wr_en) begin
        delim_r <= cfg_wr_data;
      end
    end
  end

  dts_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept),
    .load_res  (res),
    .load_cnt  (res_cnt),
    .ready     (ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head),
    .head_last (out_run_last)
  );

  assign out_kind         = head.kind;
  assign out_byte         = head.data;
  assign out_tokens_found = head.count;

`ifndef SYNTHESIS
  a_line_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_line_last |=> st_r.ls && !st_r.failed && !st_r.esc &&
                                   (st_r.ttot == '0) && (st_r.tlen == '0))
    else $error("line state not cleared after last byte");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_BYTE) |-> (out_byte == 8'h00))
    else $error("non-byte result carries a byte");

  a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_LINE_END) |-> (out_tokens_found == '0))
    else $error("count set on a result other than line end");

  a_failed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && st_r.failed |-> (res_cnt == '0))
    else $error("results produced after a syntax error");
`endif

endmodule

// ===== verif/tb_delimited_token_splitter.sv =====
// ----------------------------------------------------------------------------
// tb_delimited_token_splitter
// Self-checking testbench for the delimited token splitter. A behavioral
// predictor tracks the line state of the block and queues the expected beats
// for every accepted byte; each output beat is compared against the oldest
// expected beat. Directed lines cover the splitting, escape and error rules,
// then random lines run under several delimiters and idle patterns.
// ----------------------------------------------------------------------------
module tb_delimited_token_splitter;
  import dts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN  = 256;
  localparam int MAX_TOK  = 64;
  localparam int SETTLE   = 10;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         data;
    logic [COUNT_W-1:0] count;
    logic               last;
  } beat_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [7:0]         cfg_wr_data = 8'h00;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_char_byte = 8'h00;
  logic               in_line_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_kind;
  logic [7:0]         out_byte;
  logic [COUNT_W-1:0] out_tokens_found;
  logic               out_run_last;

  // Predictor state, a private copy of the line state of the block.
  logic [7:0] split_delim;
  bit         esc_held;
  logic [7:0] prev_char;
  bit         at_line_start;
  bit         line_bad;
  int         tok_len;
  int         tok_total;
  beat_t      burst[RES_CAP];
  int         burst_n;
  beat_t      expected_beats[$];

  logic [7:0] cur_delim = SPACE_BYTE;
  int         send_pct = 0;
  int         stall_pct = 0;
  int         mismatches = 0;
  int         beats_checked = 0;
  int         bytes_taken = 0;
  int         lines_taken = 0;
  int         kind_seen[4] = '{0, 0, 0, 0};

  delimited_token_splitter #(
    .MAX_TOKEN_LEN(MAX_LEN),
    .MAX_TOKENS   (MAX_TOK)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_byte    (in_char_byte),
    .in_line_last    (in_line_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_tokens_found(out_tokens_found),
    .out_run_last    (out_run_last)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  function automatic void clear_line_state();
    esc_held      = 1'b0;
    prev_char     = 8'h00;
    at_line_start = 1'b1;
    tok_len       = 0;
    tok_total     = 0;
    line_bad      = 1'b0;
  endfunction

  function automatic void put_beat(logic [1:0] k, logic [7:0] d, logic [COUNT_W-1:0] n);
    beat_t b;
    if (burst_n < RES_CAP) begin
      b.kind  = k;
      b.data  = d;
      b.count = n;
      b.last  = 1'b0;
      burst[burst_n] = b;
      burst_n++;
    end
  endfunction

  // Only the first error of a line produces a beat.
  function automatic void flag_error();
    if (!line_bad) begin
      put_beat(KIND_ERROR, 8'h00, '0);
      line_bad = 1'b1;
    end
  endfunction

  function automatic void add_char(logic [7:0] c);
    if (tok_len >= MAX_LEN - 1) begin
      flag_error();
    end else begin
      put_beat(KIND_BYTE, c, '0);
      tok_len++;
    end
  endfunction

  function automatic void close_token();
    if (tok_total >= MAX_TOK) begin
      flag_error();
    end else begin
      put_beat(KIND_TOKEN_END, 8'h00, '0);
      tok_total++;
      tok_len = 0;
    end
  endfunction

  function automatic void take_char(logic [7:0] c);
    if (!line_bad) begin
      if (c == split_delim &&
          (split_delim == SPACE_BYTE || prev_char == SPACE_BYTE || at_line_start)) begin
        if (tok_len == 0) begin
          if (split_delim != SPACE_BYTE) flag_error();
        end else begin
          close_token();
        end
      end else if (!(tok_len == 0 && c == SPACE_BYTE)) begin
        add_char(c);
      end
      prev_char     = c;
      at_line_start = 1'b0;
    end
  endfunction

  // Works out every beat that one accepted byte causes and queues them.
  function automatic void split_byte(logic [7:0] c, logic last);
    bit    taken;
    beat_t b;
    burst_n = 0;
    taken   = 1'b0;
    if (!line_bad) begin
      if (last && c == split_delim && split_delim != SPACE_BYTE) begin
        flag_error();
      end else begin
        if (esc_held) begin
          esc_held = 1'b0;
          if (c == split_delim) begin
            add_char(c);
            prev_char     = c;
            at_line_start = 1'b0;
            taken         = 1'b1;
          end else begin
            take_char(ESCAPE_BYTE);
          end
        end
        if (!taken && !line_bad) begin
          if (!last && c == ESCAPE_BYTE) esc_held = 1'b1;
          else take_char(c);
        end
      end
    end
    if (last) begin
      if (!line_bad) begin
        if (tok_len > 0) close_token();
        if (!line_bad) put_beat(KIND_LINE_END, 8'h00, COUNT_W'(tok_total));
      end
      clear_line_state();
    end
    for (int i = 0; i < burst_n; i++) begin
      b = burst[i];
      b.last = (i == burst_n - 1);
      expected_beats.push_back(b);
    end
  endfunction

  function automatic void report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  // Predicts on accepted input beats and checks accepted output beats.
  always @(posedge clk) begin : beat_monitor
    beat_t want;
    if (!rst_n) begin
      split_delim = SPACE_BYTE;
      clear_line_state();
    end else begin
      if (cfg_wr_en) split_delim = cfg_wr_data;
      if (in_valid && !in_stall) begin
        split_byte(in_char_byte, in_line_last);
        bytes_taken++;
        if (in_line_last) lines_taken++;
      end
      if (out_valid && !out_stall) begin
        beats_checked++;
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected beat kind=%0d byte=%02h count=%0d last=%0b",
                                    out_kind, out_byte, out_tokens_found, out_run_last));
        end else begin
          want = expected_beats.pop_front();
          kind_seen[want.kind]++;
          if (out_kind !== want.kind || out_byte !== want.data ||
              out_tokens_found !== want.count || out_run_last !== want.last) begin
            report_mismatch($sformatf(
              "expected kind=%0d byte=%02h count=%0d last=%0b, got %0d %02h %0d %0b",
              want.kind, want.data, want.count, want.last,
              out_kind, out_byte, out_tokens_found, out_run_last));
          end
        end
      end
    end
  end

  task automatic set_idle(input int mode);
    send_pct  = (mode == 1) ? 59 : (mode == 3) ? 28 : 0;
    stall_pct = (mode == 2) ? 59 : (mode == 3) ? 28 : 0;
  endtask

  // Holds the input off until every expected beat has left the block.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_delimiter(input logic [7:0] d);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= d;
    cur_delim    = d;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic send_char(input logic [7:0] c, input logic last);
    while (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_byte <= c;
    in_line_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_text_part();
    send_char(8'h74, 1'b0);
    send_char(SPACE_BYTE, 1'b0);
  endtask

  task automatic test_space_rules();
    set_idle(3);
    send_text("  ab  c ");
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_text("a\\b");
    send_text("\\ x");
    send_text("q\\");
    wait_idle();
  endtask

  task automatic test_custom_delimiter();
    set_delimiter(8'h2C);
    send_text(",a");
    send_text("a ,b\\,c");
    send_text("x,");
    send_text("\\,");
    send_text("\\,z");
    wait_idle();
    set_delimiter(SPACE_BYTE);
  endtask

  // The first bytes fill a token up to its longest legal length and the
  // final byte of the line runs past it.
  task automatic test_long_token();
    set_idle(0);
    for (int i = 0; i < MAX_LEN; i++) send_char(8'h6B, i == MAX_LEN - 1);
    wait_idle();
  endtask

  // The full number of tokens closes normally, one more token is refused.
  task automatic test_token_count();
    set_idle(2);
    for (int i = 0; i < MAX_TOK; i++) send_text_part();
    send_char(8'h74, 1'b1);
    wait_idle();
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return cur_delim;
    else if (r < 35) return SPACE_BYTE;
    else if (r < 45) return ESCAPE_BYTE;
    else if (r < 85) return 8'($urandom_range(97, 122));
    else return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_line(output int n);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) n = $urandom_range(1, 10);
    else if (r < 95) n = $urandom_range(11, 40);
    else n = $urandom_range(41, 90);
    for (int i = 0; i < n; i++) send_char(pick_char(), i == n - 1);
  endtask

  // Raw bytes with line ends anywhere, to break up the well-formed lines.
  task automatic send_noise(output int n);
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end
    send_char(pick_char(), 1'b1);
    n++;
  endtask

  task automatic test_random_lines();
    int         sent;
    int         n;
    logic [7:0] d;
    for (int mode = 0; mode < 4; mode++) begin
      for (int k = 0; k < 3; k++) begin
        case ((mode * 3 + k) % 6)
          0:       d = SPACE_BYTE;
          1:       d = 8'h2C;
          2:       d = 8'h00;
          3:       d = 8'hFF;
          4:       d = ESCAPE_BYTE;
          default: d = 8'($urandom_range(0, 255));
        endcase
        set_delimiter(d);
        set_idle(mode);
        sent = 0;
        while (sent < 5) begin
          if ($urandom_range(0, 9) == 0) send_noise(n);
          else send_random_line(n);
          sent += n;
        end
        wait_idle();
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_space_rules();
    test_custom_delimiter();
    test_long_token();
    test_token_count();
    test_random_lines();
    wait_idle();
    repeat (2 * SETTLE) @(posedge clk);
    if (expected_beats.size() != 0) begin
      $display("ERROR: %0d expected beats never arrived", expected_beats.size());
    end
    $display("Sent %0d bytes in %0d lines under six delimiters and four idle patterns.",
             bytes_taken, lines_taken);
    $display("Checked %0d beats: %0d bytes, %0d token ends, %0d line ends, %0d errors.",
             beats_checked, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("ERROR: run timed out");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
